### sv/itexp_pkg.sv
// Shared constants, types and helpers for the image token expander.
`default_nettype none

package itexp_pkg;

  localparam int MAX_SIDE      = 8;
  localparam int POSITION_BITS = 21;

  localparam int TOKEN_W   = 18;
  localparam int GRID_IN_W = 4;
  localparam int POS_OUT_W = 21;
  localparam int INDEX_W   = 20;
  localparam int COUNT_W   = 21;
  localparam int LIMIT_W   = 21;
  localparam int ERR_W     = 2;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CTR_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int PROD_W = 2 * SIDE_W;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_PAD_TOKEN_ID = 1'b0;
  localparam logic REG_TOKEN_LIMIT  = 1'b1;

  localparam logic [TOKEN_W-1:0] PAD_TOKEN_RESET = '0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = LIMIT_W'(32768);

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE       = 2'd0,
    ERR_EMPTY_GRID = 2'd1,
    ERR_LIMIT      = 2'd2
  } err_code_t;

  typedef struct packed {
    logic      load_text;
    logic      load_err;
    err_code_t err_code;
    logic      start_image;
    logic      step_image;
  } dp_cmd_t;

  typedef struct packed {
    logic is_pad;
    logic grid_empty;
    logic over_limit;
    logic single_cell;
    logic walk_last;
    logic grid_idle;
    logic out_free;
  } dp_status_t;

  function automatic logic [SIDE_W-1:0] sat_side(input logic [GRID_IN_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v > GRID_IN_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/itexp_if.sv
// Input and result channel interfaces of the image token expander.
`default_nettype none

interface itexp_in_if;
  import itexp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TOKEN_W-1:0]   token_value;
  logic [GRID_IN_W-1:0] image_rows;
  logic [GRID_IN_W-1:0] image_columns;

  modport source(output valid, token_value, image_rows, image_columns, input ready);
  modport sink(input valid, token_value, image_rows, image_columns, output ready);
endinterface

interface itexp_out_if;
  import itexp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TOKEN_W-1:0]   out_token;
  logic [POS_OUT_W-1:0] pos_temporal;
  logic [POS_OUT_W-1:0] pos_height;
  logic [POS_OUT_W-1:0] pos_width;
  logic [INDEX_W-1:0]   out_index;
  logic                 is_image;
  logic [ERR_W-1:0]     error_code;
  logic                 run_last;

  modport source(output valid, out_token, pos_temporal, pos_height, pos_width,
                 out_index, is_image, error_code, run_last, input ready);
  modport sink(input valid, out_token, pos_temporal, pos_height, pos_width,
               out_index, is_image, error_code, run_last, output ready);
endinterface

`default_nettype wire

### sv/itexp_ctrl.sv
// Controller state machine: item accept, error decision and grid walk sequencing.
`default_nettype none

module itexp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  itexp_pkg::dp_status_t status,
  output itexp_pkg::dp_cmd_t    cmd
);
  import itexp_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXPAND
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next      = state;
    cmd.load_text   = 1'b0;
    cmd.load_err    = 1'b0;
    cmd.err_code    = ERR_NONE;
    cmd.start_image = 1'b0;
    cmd.step_image  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!status.is_pad) begin
            if (status.over_limit) begin
              cmd.load_err = 1'b1;
              cmd.err_code = ERR_LIMIT;
            end else begin
              cmd.load_text = 1'b1;
            end
          end else if (status.grid_empty) begin
            cmd.load_err = 1'b1;
            cmd.err_code = ERR_EMPTY_GRID;
          end else if (status.over_limit) begin
            cmd.load_err = 1'b1;
            cmd.err_code = ERR_LIMIT;
          end else begin
            cmd.start_image = 1'b1;
            if (!status.single_cell) begin
              state_next = ST_EXPAND;
            end
          end
        end
      end
      ST_EXPAND: begin
        if (status.out_free) begin
          cmd.step_image = 1'b1;
          if (status.walk_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### sv/itexp_dp.sv
// Datapath: position and count state, grid walk counters, result register.
`default_nettype none

module itexp_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  itexp_pkg::dp_cmd_t              cmd,
  output itexp_pkg::dp_status_t           status,
  input  logic [itexp_pkg::TOKEN_W-1:0]   token_value,
  input  logic [itexp_pkg::GRID_IN_W-1:0] image_rows,
  input  logic [itexp_pkg::GRID_IN_W-1:0] image_columns,
  input  logic [itexp_pkg::TOKEN_W-1:0]   pad_token_id,
  input  logic [itexp_pkg::LIMIT_W-1:0]   token_limit,
  itexp_out_if.source                     out_ch
);
  import itexp_pkg::*;

  logic [POSITION_BITS-1:0] running_position;
  logic [COUNT_W-1:0]       emitted_count;
  logic [CTR_W-1:0]         row_counter;
  logic [CTR_W-1:0]         column_counter;
  logic [SIDE_W-1:0]        held_rows;
  logic [SIDE_W-1:0]        held_columns;
  logic                     out_valid;

  logic [TOKEN_W-1:0]   out_token;
  logic [POS_OUT_W-1:0] pos_temporal;
  logic [POS_OUT_W-1:0] pos_height;
  logic [POS_OUT_W-1:0] pos_width;
  logic [INDEX_W-1:0]   out_index;
  logic                 is_image;
  logic [ERR_W-1:0]     error_code;
  logic                 run_last;

  logic [SIDE_W-1:0]  sat_rows;
  logic [SIDE_W-1:0]  sat_cols;
  logic [PROD_W-1:0]  grid_count;
  logic [COUNT_W:0]   need_count;
  logic [CTR_W-1:0]   walk_r;
  logic [CTR_W-1:0]   walk_c;
  logic [SIDE_W-1:0]  walk_rows;
  logic [SIDE_W-1:0]  walk_cols;
  logic               col_end;
  logic               row_end;
  logic               elem_last;
  logic [CTR_W-1:0]   next_r;
  logic [CTR_W-1:0]   next_c;
  logic [SIDE_W-1:0]  walk_max;
  logic               emit_image;
  logic               load_any;

  assign sat_rows   = sat_side(image_rows);
  assign sat_cols   = sat_side(image_columns);
  assign grid_count = PROD_W'(sat_rows) * PROD_W'(sat_cols);
  assign need_count = status.is_pad ? (COUNT_W + 1)'(grid_count) : (COUNT_W + 1)'(1);

  assign emit_image = cmd.start_image || cmd.step_image;
  assign load_any   = emit_image || cmd.load_text || cmd.load_err;

  assign walk_r    = cmd.start_image ? '0 : row_counter;
  assign walk_c    = cmd.start_image ? '0 : column_counter;
  assign walk_rows = cmd.start_image ? sat_rows : held_rows;
  assign walk_cols = cmd.start_image ? sat_cols : held_columns;
  assign col_end   = (SIDE_W'(walk_c) + SIDE_W'(1)) == walk_cols;
  assign row_end   = (SIDE_W'(walk_r) + SIDE_W'(1)) == walk_rows;
  assign elem_last = col_end && row_end;
  assign next_r    = col_end ? walk_r + CTR_W'(1) : walk_r;
  assign next_c    = col_end ? '0 : walk_c + CTR_W'(1);
  assign walk_max  = (walk_rows > walk_cols) ? walk_rows : walk_cols;

  assign status.is_pad      = token_value == pad_token_id;
  assign status.grid_empty  = (image_rows == '0) || (image_columns == '0);
  assign status.over_limit  = ({1'b0, emitted_count} + need_count) > (COUNT_W + 1)'(token_limit);
  assign status.single_cell = (sat_rows == SIDE_W'(1)) && (sat_cols == SIDE_W'(1));
  assign status.walk_last   = ((SIDE_W'(row_counter) + SIDE_W'(1)) == held_rows) &&
                              ((SIDE_W'(column_counter) + SIDE_W'(1)) == held_columns);
  assign status.grid_idle   = (row_counter == '0) && (column_counter == '0);
  assign status.out_free    = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_position <= '0;
      emitted_count    <= '0;
      row_counter      <= '0;
      column_counter   <= '0;
      held_rows        <= '0;
      held_columns     <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (load_any) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load_text) begin
        emitted_count    <= emitted_count + COUNT_W'(1);
        running_position <= running_position + POSITION_BITS'(1);
      end
      if (emit_image) begin
        emitted_count <= emitted_count + COUNT_W'(1);
        if (cmd.start_image) begin
          held_rows    <= sat_rows;
          held_columns <= sat_cols;
        end
        if (elem_last) begin
          row_counter      <= '0;
          column_counter   <= '0;
          running_position <= running_position + POSITION_BITS'(walk_max);
        end else begin
          row_counter    <= next_r;
          column_counter <= next_c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_token    <= '0;
      pos_temporal <= '0;
      pos_height   <= '0;
      pos_width    <= '0;
      out_index    <= '0;
      is_image     <= 1'b0;
      error_code   <= cmd.err_code;
      run_last     <= 1'b1;
    end else if (cmd.load_text) begin
      out_token    <= token_value;
      pos_temporal <= POS_OUT_W'(running_position);
      pos_height   <= POS_OUT_W'(running_position);
      pos_width    <= POS_OUT_W'(running_position);
      out_index    <= emitted_count[INDEX_W-1:0];
      is_image     <= 1'b0;
      error_code   <= ERR_NONE;
      run_last     <= 1'b1;
    end else if (emit_image) begin
      out_token    <= pad_token_id;
      pos_temporal <= POS_OUT_W'(running_position);
      pos_height   <= POS_OUT_W'(running_position + POSITION_BITS'(walk_r));
      pos_width    <= POS_OUT_W'(running_position + POSITION_BITS'(walk_c));
      out_index    <= emitted_count[INDEX_W-1:0];
      is_image     <= 1'b1;
      error_code   <= ERR_NONE;
      run_last     <= elem_last;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.out_token    = out_token;
  assign out_ch.pos_temporal = pos_temporal;
  assign out_ch.pos_height   = pos_height;
  assign out_ch.pos_width    = pos_width;
  assign out_ch.out_index    = out_index;
  assign out_ch.is_image     = is_image;
  assign out_ch.error_code   = error_code;
  assign out_ch.run_last     = run_last;

endmodule

`default_nettype wire

### sv/image_token_expand_mrope_positions.sv
// Top level: configuration registers, controller and datapath of the image token expander.
// A result sits in the output register from the cycle after its item is accepted.
// A text token or an error yields one result; an image pad yields rows*columns results,
// one per cycle while the output is free, paced by the grid walk counters in the datapath.
// A waiting result holds off the next item; it enters in the cycle that result is taken.
// Reset (synchronous, active high) clears positions, counts and walk state, and sets
// pad_token_id to 0 and token_limit to 32768.
`default_nettype none

module image_token_expand_mrope_positions (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [itexp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [itexp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [itexp_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  itexp_in_if.sink                         in_ch,
  itexp_out_if.source                      out_ch
);
  import itexp_pkg::*;

  logic [TOKEN_W-1:0] pad_token_id;
  logic [LIMIT_W-1:0] token_limit;
  logic               cfg_write;
  dp_cmd_t            cmd;
  dp_status_t         status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_token_id <= PAD_TOKEN_RESET;
      token_limit  <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_PAD_TOKEN_ID: pad_token_id <= pwdata[TOKEN_W-1:0];
        REG_TOKEN_LIMIT:  token_limit  <= pwdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PAD_TOKEN_ID: prdata = APB_DATA_W'(pad_token_id);
      REG_TOKEN_LIMIT:  prdata = APB_DATA_W'(token_limit);
      default:          prdata = '0;
    endcase
  end

  itexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  itexp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .token_value   (in_ch.token_value),
    .image_rows    (in_ch.image_rows),
    .image_columns (in_ch.image_columns),
    .pad_token_id  (pad_token_id),
    .token_limit   (token_limit),
    .out_ch        (out_ch)
  );

  a_accept_grid_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |-> status.grid_idle)
    else $error("item accepted during a grid walk");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.error_code != ERR_NONE) |->
      out_ch.run_last && !out_ch.is_image && (out_ch.out_token == '0))
    else $error("error result with payload");

  a_image_token: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.is_image |->
      (out_ch.out_token == pad_token_id) && (out_ch.error_code == ERR_NONE))
    else $error("image result with wrong token");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_text, cmd.load_err, cmd.start_image, cmd.step_image}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire
